/* sv/rkdl_pkg.sv */
// Package for the rotary knob detent limiter: register indexes, field widths,
// reset values and the payload types. No dependencies.
package rkdl_pkg;

    localparam int unsigned CNT_W     = 4;   // low counters, low_polls_needed
    localparam int unsigned DET_W     = 8;   // polls_since_detent, interlock_polls
    localparam int unsigned EMIT_W    = 10;  // polls_since_emit, emit_gap_polls
    localparam int unsigned CAP_W     = 7;   // saturation limit of pending
    localparam int unsigned PEND_W    = 8;   // pending, pending_after
    localparam int unsigned STEP_W    = 2;   // step
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 10;
    localparam int unsigned IN_TD_W   = 8;
    localparam int unsigned OUT_TD_W  = 16;

    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [PEND_W-1:0] t_pend;
    typedef logic signed [STEP_W-1:0] t_step;

    localparam t_cfg_idx REG_LOW_POLLS  = 3'd0;
    localparam t_cfg_idx REG_INTERLOCK  = 3'd1;
    localparam t_cfg_idx REG_EMIT_GAP   = 3'd2;
    localparam t_cfg_idx REG_PEND_CAP   = 3'd3;
    localparam t_cfg_idx REG_REVERSE    = 3'd4;

    localparam logic [CNT_W-1:0]  RST_LOW_POLLS = 4'd2;
    localparam logic [DET_W-1:0]  RST_INTERLOCK = 8'd5;
    localparam logic [EMIT_W-1:0] RST_EMIT_GAP  = 10'd20;
    localparam logic [CAP_W-1:0]  RST_PEND_CAP  = 7'd18;

    localparam t_step STEP_UP   = 2'sd1;
    localparam t_step STEP_DOWN = -2'sd1;

endpackage

/* sv/rotary_knob_detent_limiter.sv */
// Rotary knob detent limiter: polled two-channel detent decoder with an
// interlock window and a rate-limited, saturating pending count.
// Depends on rkdl_pkg.
//
//  channel   signals                               direction  item
//  s_axis    tvalid tready tdata[7:0]              in         one poll of A and B
//  m_axis    tvalid tready tdata[15:0]             out        one emitted step
//  cfg       i_cfg_valid o_cfg_ready index data    in         one register write
//
// One poll is taken per cycle unless a step waits at a stalled output; its result,
// if any, is in the output register on the next cycle. The decode, interlock, clamp
// and emit decision all settle in one pass from the state registers at the accepting edge.
// Reset (synchronous, active low) restores register defaults and clears state.
// A poll is taken whenever the output register is empty or drains this cycle,
// so a stalled output holds the input side only while a step waits.
module rotary_knob_detent_limiter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rkdl_pkg::IN_TD_W-1:0]   s_axis_tdata,   // [0] level_a, [1] level_b
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rkdl_pkg::OUT_TD_W-1:0]  m_axis_tdata,   // [1:0] step, [9:2] pending_after
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rkdl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rkdl_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import rkdl_pkg::*;

    // configuration
    logic [CNT_W-1:0]  r_low_polls;
    logic [DET_W-1:0]  r_interlock;
    logic [EMIT_W-1:0] r_emit_gap;
    logic [CAP_W-1:0]  r_pend_cap;
    logic              r_reverse;

    // poll state
    logic              r_prev_a, r_prev_b;
    t_cnt              r_cnt_a, r_cnt_b;
    logic [DET_W-1:0]  r_since_det;
    logic [EMIT_W-1:0] r_since_emit;
    t_pend             r_pend;

    // output stage
    logic              r_out_valid;
    t_step             r_out_step;
    t_pend             r_out_pend;

    logic              n_prev_a, n_prev_b;
    t_cnt              n_cnt_a, n_cnt_b;
    logic [DET_W-1:0]  n_since_det;
    logic [EMIT_W-1:0] n_since_emit;
    t_pend             n_pend;
    logic              n_emit;
    t_step             n_step;

    logic              lvl_a, lvl_b, fire_a, fire_b, acc_a, acc_b, blocked;
    logic [DET_W-1:0]  det_inc;
    logic [EMIT_W-1:0] emit_inc;
    logic [1:0]        delta;      // signed sum of accepted detents
    logic signed [PEND_W:0] sum, cap_pos, cap_neg;
    t_pend             pend_clamped;
    logic              accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign lvl_a         = s_axis_tdata[0];
    assign lvl_b         = s_axis_tdata[1];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TD_W-PEND_W-STEP_W){1'b0}}, r_out_pend, r_out_step};

    always_comb begin
        det_inc  = (r_since_det  == '1) ? r_since_det  : r_since_det  + 1'b1;
        emit_inc = (r_since_emit == '1) ? r_since_emit : r_since_emit + 1'b1;

        // channel A: clear on high or on first low poll, count up on held low
        fire_a  = r_prev_a == 1'b0 && lvl_a &&
                  ({1'b0, r_cnt_a} + 5'd1) >= {1'b0, r_low_polls};
        if (lvl_a || r_prev_a)    n_cnt_a = '0;
        else if (r_cnt_a != '1)   n_cnt_a = r_cnt_a + 1'b1;
        else                      n_cnt_a = r_cnt_a;

        fire_b  = r_prev_b == 1'b0 && lvl_b &&
                  ({1'b0, r_cnt_b} + 5'd1) >= {1'b0, r_low_polls};
        if (lvl_b || r_prev_b)    n_cnt_b = '0;
        else if (r_cnt_b != '1)   n_cnt_b = r_cnt_b + 1'b1;
        else                      n_cnt_b = r_cnt_b;

        n_prev_a = lvl_a;
        n_prev_b = lvl_b;

        // drop detents inside the interlock window
        blocked     = det_inc < r_interlock;
        acc_a       = fire_a && !blocked;
        acc_b       = fire_b && !blocked;
        n_since_det = (acc_a || acc_b) ? '0 : det_inc;

        // A is down unless reversed; both at once cancel
        if (acc_a == acc_b)          delta = 2'sb00;
        else if (acc_a ^ r_reverse)  delta = 2'sb11;
        else                         delta = 2'sb01;

        cap_pos = $signed({2'b00, r_pend_cap});
        cap_neg = -cap_pos;
        sum     = $signed({r_pend[PEND_W-1], r_pend}) + $signed({{(PEND_W-1){delta[1]}}, delta});
        priority if (sum > cap_pos) pend_clamped = cap_pos[PEND_W-1:0];
        else if (sum < cap_neg)     pend_clamped = cap_neg[PEND_W-1:0];
        else                        pend_clamped = sum[PEND_W-1:0];
        if (delta == 2'b00) pend_clamped = r_pend;

        // drain one step per emit gap
        n_emit = pend_clamped != '0 && emit_inc >= r_emit_gap;
        n_step = pend_clamped[PEND_W-1] ? STEP_DOWN : STEP_UP;
        if (n_emit) begin
            n_since_emit = '0;
            n_pend       = pend_clamped - {{(PEND_W-STEP_W){n_step[STEP_W-1]}}, n_step};
        end else begin
            n_since_emit = emit_inc;
            n_pend       = pend_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_polls  <= RST_LOW_POLLS;
            r_interlock  <= RST_INTERLOCK;
            r_emit_gap   <= RST_EMIT_GAP;
            r_pend_cap   <= RST_PEND_CAP;
            r_reverse    <= 1'b0;
            r_prev_a     <= 1'b1;
            r_prev_b     <= 1'b1;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_since_det  <= '1;
            r_since_emit <= '1;
            r_pend       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_LOW_POLLS: r_low_polls <= i_cfg_data[CNT_W-1:0];
                    REG_INTERLOCK: r_interlock <= i_cfg_data[DET_W-1:0];
                    REG_EMIT_GAP:  r_emit_gap  <= i_cfg_data[EMIT_W-1:0];
                    REG_PEND_CAP:  r_pend_cap  <= i_cfg_data[CAP_W-1:0];
                    REG_REVERSE:   r_reverse   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_prev_a     <= n_prev_a;
                r_prev_b     <= n_prev_b;
                r_cnt_a      <= n_cnt_a;
                r_cnt_b      <= n_cnt_b;
                r_since_det  <= n_since_det;
                r_since_emit <= n_since_emit;
                r_pend       <= n_pend;
                r_out_valid  <= n_emit;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // payload of the output stage
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out_step <= n_step;
            r_out_pend <= n_pend;
        end
    end

endmodule
